>>> design/rrbp_pkg.sv
`timescale 1ns / 1ps
package rrbp_pkg;
  localparam int SURFACES = 8;
  localparam int POOL_DEPTH = 4;
  localparam int IN_FLIGHT = 16;
  localparam int ID_BITS = 32;
  localparam int SURF_BITS = 3;
  localparam int SLOT_BITS = 2;
  localparam int CNT_BITS = 3;
  localparam int MAP_BITS = 4;
  localparam int POOL_ADDR_BITS = 5;
  localparam int POOL_WORDS = SURFACES * POOL_DEPTH;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_RESERVE = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_DONE = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_POOL = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_NO_MAPPING = 3'd5;
  localparam logic [2:0] ST_MISMATCH = 3'd6;
endpackage

>>> design/rrbp_ram.sv
`timescale 1ns / 1ps
module rrbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/round_robin_buffer_pool_reserver.sv
`timescale 1ns / 1ps
// Keeps a pool of up to four buffer ids per surface and a table of sixteen
// in-flight presents, each holding one buffer.
// A request enters on the in_ channel (in_valid, in_stall) and carries an
// action, a surface, and ids. Exactly one result leaves on the out_ channel
// (out_valid, out_stall) for every request, in order.
// One request is worked on at a time. Release, done, unknown actions and any
// request on a surface with an empty pool pass through the read and finish
// states only, with no pool read. Add, clear and reserve read the surface's
// pool one entry at a time (address, then compare), up to 4 entries, before
// the result is presented. Add and clear read every entry; reserve stops at
// the first free buffer. The next request is accepted in the cycle after the
// result leaves. The pool memory has one read port with a registered read,
// which is why each entry takes an address step and a compare step. The map
// table sits in flip-flops and is searched in parallel.
// Reset clears the pool counts, the round-robin indexes and all map valid
// bits; there is no clearing pass.
// The result waits in an output register while out_stall is high. The next
// request is taken only after the result has left.
module round_robin_buffer_pool_reserver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_surface,
  input  logic [31:0] in_buffer_id,
  input  logic [31:0] in_present_tag,
  input  logic        in_has_expected,
  input  logic [31:0] in_expected_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [31:0] out_result_buffer,
  output logic [2:0]  out_status
);
  localparam int NB = rrbp_pkg::ID_BITS;
  localparam int MB = rrbp_pkg::MAP_BITS;
  localparam int SB = rrbp_pkg::SLOT_BITS;
  localparam int CB = rrbp_pkg::CNT_BITS;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_CHECK, S_FIN, S_OUT} state_t;

  state_t state_r;
  logic [2:0] act_r;
  logic [rrbp_pkg::SURF_BITS-1:0] surf_r;
  logic [NB-1:0] buf_r, tag_r, exp_r;
  logic hasexp_r;
  logic [CB-1:0] cnt_r [rrbp_pkg::SURFACES];
  logic [SB-1:0] nxt_r [rrbp_pkg::SURFACES];
  logic [rrbp_pkg::IN_FLIGHT-1:0] mvalid_r;
  logic [NB-1:0] mpres_r [rrbp_pkg::IN_FLIGHT];
  logic [NB-1:0] mbuf_r [rrbp_pkg::IN_FLIGHT];
  logic [CB-1:0] step_r;
  logic [SB-1:0] idx_r;
  logic found_r, dup_r;
  logic [NB-1:0] cand_r;
  logic [SB-1:0] candi_r;
  logic granted_r;
  logic [31:0] rbuf_r;
  logic [2:0] status_r;
  logic granted_nxt;
  logic [31:0] rbuf_nxt;
  logic [2:0] status_nxt;

  logic we;
  logic [rrbp_pkg::POOL_ADDR_BITS-1:0] waddr, raddr;
  logic [NB-1:0] rdata;

  rrbp_ram #(.WIDTH(NB), .DEPTH(rrbp_pkg::POOL_WORDS)) u_pool (
    .clk(clk), .we(we), .waddr(waddr), .wdata(buf_r), .raddr(raddr), .rdata(rdata)
  );

  logic [CB-1:0] n;
  assign n = cnt_r[surf_r];
  assign raddr = {surf_r, idx_r};
  assign waddr = {surf_r, n[SB-1:0]};
  assign we = (state_r == S_FIN) && (act_r == rrbp_pkg::ACT_ADD) && !dup_r &&
              (n < CB'(rrbp_pkg::POOL_DEPTH));

  logic held;
  logic [rrbp_pkg::IN_FLIGHT-1:0] held_v, pres_v;
  logic pres_hit, free_hit;
  logic [MB-1:0] pres_i, free_i;
  always_comb begin
    pres_hit = 1'b0;
    free_hit = 1'b0;
    pres_i = '0;
    free_i = '0;
    for (int i = 0; i < rrbp_pkg::IN_FLIGHT; i++) begin
      held_v[i] = mvalid_r[i] && (mbuf_r[i] == rdata);
      pres_v[i] = mvalid_r[i] && (mpres_r[i] == tag_r);
    end
    for (int i = rrbp_pkg::IN_FLIGHT - 1; i >= 0; i--) begin
      if (pres_v[i]) begin
        pres_hit = 1'b1;
        pres_i = MB'(i);
      end
      if (!mvalid_r[i]) begin
        free_hit = 1'b1;
        free_i = MB'(i);
      end
    end
    held = |held_v;
  end

  logic [SB-1:0] idx_inc;
  always_comb begin
    if ({1'b0, idx_r} + (SB+1)'(1) >= (SB+1)'(n)) idx_inc = '0;
    else idx_inc = idx_r + SB'(1);
  end

  logic [SB-1:0] start;
  always_comb begin
    start = nxt_r[surf_r];
    if (CB'(start) >= n && n != '0) start = SB'(CB'(start) - n);
    if (CB'(start) >= n && n != '0) start = SB'(CB'(start) - n);
    if (CB'(start) >= n && n != '0) start = SB'(CB'(start) - n);
  end

  always_comb begin
    granted_nxt = 1'b0;
    rbuf_nxt = '0;
    status_nxt = rrbp_pkg::ST_OK;
    unique case (act_r)
      rrbp_pkg::ACT_ADD: begin
        if (dup_r) status_nxt = rrbp_pkg::ST_DUPLICATE;
        else if (n >= CB'(rrbp_pkg::POOL_DEPTH)) status_nxt = rrbp_pkg::ST_TABLE_FULL;
      end
      rrbp_pkg::ACT_RESERVE: begin
        if (n == '0) status_nxt = rrbp_pkg::ST_NO_POOL;
        else if (!found_r) status_nxt = rrbp_pkg::ST_EXHAUSTED;
        else if (!pres_hit && !free_hit) status_nxt = rrbp_pkg::ST_TABLE_FULL;
        else begin
          granted_nxt = 1'b1;
          rbuf_nxt = cand_r;
        end
      end
      rrbp_pkg::ACT_RELEASE: begin
        if (!pres_hit) status_nxt = rrbp_pkg::ST_NO_MAPPING;
        else if (hasexp_r && mbuf_r[pres_i] != exp_r) status_nxt = rrbp_pkg::ST_MISMATCH;
      end
      rrbp_pkg::ACT_DONE: begin
        if (!pres_hit) status_nxt = rrbp_pkg::ST_NO_MAPPING;
        else begin
          granted_nxt = 1'b1;
          rbuf_nxt = mbuf_r[pres_i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      surf_r <= '0;
      mvalid_r <= '0;
      for (int i = 0; i < rrbp_pkg::SURFACES; i++) begin
        cnt_r[i] <= '0;
        nxt_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            surf_r <= in_surface;
            buf_r <= in_buffer_id;
            tag_r <= in_present_tag;
            hasexp_r <= in_has_expected;
            exp_r <= in_expected_buffer;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          step_r <= '0;
          found_r <= 1'b0;
          dup_r <= 1'b0;
          idx_r <= (act_r == rrbp_pkg::ACT_RESERVE) ? start : '0;
          if ((act_r == rrbp_pkg::ACT_ADD || act_r == rrbp_pkg::ACT_CLEAR ||
               act_r == rrbp_pkg::ACT_RESERVE) && n != '0) state_r <= S_WAIT;
          else state_r <= S_FIN;
        end
        S_WAIT: state_r <= S_CHECK;
        S_CHECK: begin
          if (act_r == rrbp_pkg::ACT_ADD && rdata == buf_r) dup_r <= 1'b1;
          if (act_r == rrbp_pkg::ACT_CLEAR) mvalid_r <= mvalid_r & ~held_v;
          if (act_r == rrbp_pkg::ACT_RESERVE && !held) begin
            found_r <= 1'b1;
            cand_r <= rdata;
            candi_r <= idx_r;
            state_r <= S_FIN;
          end else if (step_r + CB'(1) >= n) begin
            state_r <= S_FIN;
          end else begin
            step_r <= step_r + CB'(1);
            idx_r <= idx_inc;
            state_r <= S_WAIT;
          end
        end
        S_FIN: begin
          granted_r <= granted_nxt;
          rbuf_r <= rbuf_nxt;
          status_r <= status_nxt;
          unique case (act_r)
            rrbp_pkg::ACT_ADD: begin
              if (status_nxt == rrbp_pkg::ST_OK) begin
                if (n == '0) nxt_r[surf_r] <= '0;
                cnt_r[surf_r] <= n + CB'(1);
              end
            end
            rrbp_pkg::ACT_CLEAR: begin
              cnt_r[surf_r] <= '0;
              nxt_r[surf_r] <= '0;
            end
            rrbp_pkg::ACT_RESERVE: begin
              if (granted_nxt) begin
                mvalid_r[pres_hit ? pres_i : free_i] <= 1'b1;
                mpres_r[pres_hit ? pres_i : free_i] <= tag_r;
                mbuf_r[pres_hit ? pres_i : free_i] <= cand_r;
                nxt_r[surf_r] <= ({1'b0, candi_r} + (SB+1)'(1) >= (SB+1)'(n)) ? '0
                                 : candi_r + SB'(1);
              end
            end
            rrbp_pkg::ACT_RELEASE: begin
              if (status_nxt == rrbp_pkg::ST_OK) mvalid_r[pres_i] <= 1'b0;
            end
            rrbp_pkg::ACT_DONE: begin
              if (granted_nxt) mvalid_r[pres_i] <= 1'b0;
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_granted = granted_r;
  assign out_result_buffer = rbuf_r;
  assign out_status = status_r;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("input open while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[surf_r] <= CB'(rrbp_pkg::POOL_DEPTH)) else $error("pool count too large");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_buffer))
    else $error("result dropped");
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_status == rrbp_pkg::ST_OK)
    else $error("grant with error");
`endif
endmodule

>>> tb/sv/round_robin_buffer_pool_reserver_tb.sv
`timescale 1ns / 1ps
module round_robin_buffer_pool_reserver_tb;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  surface;
    logic [31:0] buffer_id;
    logic [31:0] present_tag;
    logic        has_expected;
    logic [31:0] expected_buffer;
  } request_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] result_buffer;
    logic [2:0]  status;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   rep;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [2:0]  in_surface;
  logic [31:0] in_buffer_id;
  logic [31:0] in_present_tag;
  logic        in_has_expected;
  logic [31:0] in_expected_buffer;
  logic        out_valid;
  logic        out_stall;
  logic        out_granted;
  logic [31:0] out_result_buffer;
  logic [2:0]  out_status;

  round_robin_buffer_pool_reserver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_surface(in_surface),
    .in_buffer_id(in_buffer_id), .in_present_tag(in_present_tag),
    .in_has_expected(in_has_expected), .in_expected_buffer(in_expected_buffer),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_granted(out_granted), .out_result_buffer(out_result_buffer),
    .out_status(out_status)
  );

  logic [31:0] pool_ids [rrbp_pkg::SURFACES][rrbp_pkg::POOL_DEPTH];
  int unsigned pool_used [rrbp_pkg::SURFACES];
  int unsigned rr_index [rrbp_pkg::SURFACES];
  bit          held_valid [rrbp_pkg::IN_FLIGHT];
  logic [31:0] held_tag [rrbp_pkg::IN_FLIGHT];
  logic [31:0] held_buffer [rrbp_pkg::IN_FLIGHT];

  reply_t      expected_replies [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;

  function automatic bit buffer_is_held(logic [31:0] id);
    for (int i = 0; i < rrbp_pkg::IN_FLIGHT; i++)
      if (held_valid[i] && held_buffer[i] == id) return 1;
    return 0;
  endfunction

  function automatic bit pool_contains(int s, logic [31:0] id);
    for (int i = 0; i < pool_used[s] && i < rrbp_pkg::POOL_DEPTH; i++)
      if (pool_ids[s][i] == id) return 1;
    return 0;
  endfunction

  function automatic int find_tag(logic [31:0] tag);
    for (int i = 0; i < rrbp_pkg::IN_FLIGHT; i++)
      if (held_valid[i] && held_tag[i] == tag) return i;
    return rrbp_pkg::IN_FLIGHT;
  endfunction

  function automatic reply_t apply_request(request_t r);
    reply_t rep;
    int s, n, start, cand, slot;
    bit found;
    rep = '0;
    s = r.surface;
    case (r.action)
      rrbp_pkg::ACT_ADD: begin
        if (pool_contains(s, r.buffer_id)) rep.status = rrbp_pkg::ST_DUPLICATE;
        else if (pool_used[s] >= rrbp_pkg::POOL_DEPTH) rep.status = rrbp_pkg::ST_TABLE_FULL;
        else begin
          if (pool_used[s] == 0) rr_index[s] = 0;
          pool_ids[s][pool_used[s]] = r.buffer_id;
          pool_used[s]++;
        end
      end
      rrbp_pkg::ACT_CLEAR: begin
        for (int i = 0; i < rrbp_pkg::IN_FLIGHT; i++)
          if (held_valid[i] && pool_contains(s, held_buffer[i])) held_valid[i] = 0;
        pool_used[s] = 0;
        rr_index[s] = 0;
      end
      rrbp_pkg::ACT_RESERVE: begin
        n = pool_used[s];
        found = 0;
        cand = 0;
        if (n == 0) rep.status = rrbp_pkg::ST_NO_POOL;
        else begin
          start = rr_index[s] % n;
          for (int a = 0; a < n && !found; a++) begin
            cand = (start + a) % n;
            if (!buffer_is_held(pool_ids[s][cand])) found = 1;
          end
          if (!found) rep.status = rrbp_pkg::ST_EXHAUSTED;
          else begin
            slot = find_tag(r.present_tag);
            if (slot >= rrbp_pkg::IN_FLIGHT)
              for (int i = rrbp_pkg::IN_FLIGHT - 1; i >= 0; i--)
                if (!held_valid[i]) slot = i;
            if (slot >= rrbp_pkg::IN_FLIGHT) rep.status = rrbp_pkg::ST_TABLE_FULL;
            else begin
              held_valid[slot] = 1;
              held_tag[slot] = r.present_tag;
              held_buffer[slot] = pool_ids[s][cand];
              rr_index[s] = (cand + 1) % n;
              rep.granted = 1;
              rep.result_buffer = pool_ids[s][cand];
            end
          end
        end
      end
      rrbp_pkg::ACT_RELEASE: begin
        slot = find_tag(r.present_tag);
        if (slot >= rrbp_pkg::IN_FLIGHT) rep.status = rrbp_pkg::ST_NO_MAPPING;
        else if (r.has_expected && held_buffer[slot] != r.expected_buffer)
          rep.status = rrbp_pkg::ST_MISMATCH;
        else held_valid[slot] = 0;
      end
      rrbp_pkg::ACT_DONE: begin
        slot = find_tag(r.present_tag);
        if (slot >= rrbp_pkg::IN_FLIGHT) rep.status = rrbp_pkg::ST_NO_MAPPING;
        else begin
          rep.granted = 1;
          rep.result_buffer = held_buffer[slot];
          held_valid[slot] = 0;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = {out_granted, out_result_buffer, out_status};
        if (expected_replies.size() == 0) begin
          $error("unexpected result granted=%0d buffer=%h status=%0d",
                 out_granted, out_result_buffer, out_status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, got.granted);
            fail_count++;
          end
          if (got.result_buffer !== want.result_buffer) begin
            $error("result_buffer: expected %h, got %h",
                   want.result_buffer, got.result_buffer);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic send_request(request_t r, bit typed, reply_t typed_rep);
    reply_t rep;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    {in_action, in_surface, in_buffer_id, in_present_tag, in_has_expected,
     in_expected_buffer} <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rep = apply_request(r);
    if (typed && rep !== typed_rep) begin
      $error("predictor disagrees with table: expected %h, got %h", typed_rep, rep);
      fail_count++;
    end
    expected_replies.push_back(typed ? typed_rep : rep);
    @(negedge clk);
  endtask

  function automatic request_t mk(logic [2:0] a, int unsigned s, int unsigned b,
                                  int unsigned t, int unsigned h, int unsigned e);
    return {a, 3'(s), b, t, 1'(h), e};
  endfunction

  function automatic reply_t rp(int unsigned g, int unsigned b, logic [2:0] st);
    return {1'(g), b, st};
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.surface = $urandom_range(0, 2) == 0 ? 3'($urandom) : 3'($urandom_range(0, 2));
    r.buffer_id = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 7));
    r.present_tag = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(0, 23));
    r.has_expected = 1'($urandom);
    r.expected_buffer = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 7));
    pick = $urandom_range(99);
    if (pick < 20) r.action = rrbp_pkg::ACT_ADD;
    else if (pick < 25) r.action = rrbp_pkg::ACT_CLEAR;
    else if (pick < 60) r.action = rrbp_pkg::ACT_RESERVE;
    else if (pick < 75) r.action = rrbp_pkg::ACT_RELEASE;
    else if (pick < 96) r.action = rrbp_pkg::ACT_DONE;
    else r.action = 3'($urandom_range(5, 7));
    return r;
  endfunction

  table_row_t directed [$];

  initial begin
    int n_random;
    table_row_t row;
    in_valid = 0;
    in_action = 0;
    in_surface = 0;
    in_buffer_id = 0;
    in_present_tag = 0;
    in_has_expected = 0;
    in_expected_buffer = 0;
    rst_n = 0;
    for (int s = 0; s < rrbp_pkg::SURFACES; s++) begin
      pool_used[s] = 0;
      rr_index[s] = 0;
    end
    for (int i = 0; i < rrbp_pkg::IN_FLIGHT; i++) held_valid[i] = 0;

    directed = '{
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 1, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_NO_POOL)},
      '{mk(rrbp_pkg::ACT_DONE, 0, 0, 1, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_NO_MAPPING)},
      '{mk(rrbp_pkg::ACT_RELEASE, 0, 0, 1, 1, 0), 1, rp(0, 0, rrbp_pkg::ST_NO_MAPPING)},
      '{mk(rrbp_pkg::ACT_CLEAR, 5, 0, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(3'd5, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF), 1,
        rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(3'd7, 0, 0, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(rrbp_pkg::ACT_ADD, 7, 32'hFFFFFFFF, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(rrbp_pkg::ACT_ADD, 7, 32'hFFFFFFFF, 0, 0, 0), 1,
        rp(0, 0, rrbp_pkg::ST_DUPLICATE)},
      '{mk(rrbp_pkg::ACT_ADD, 7, 0, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(rrbp_pkg::ACT_ADD, 7, 1, 0, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_ADD, 7, 2, 0, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_ADD, 7, 3, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_TABLE_FULL)},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 32'hFFFFFFFF, 0, 0), 1,
        rp(1, 32'hFFFFFFFF, rrbp_pkg::ST_OK)},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 32'hFFFFFFFF, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 5, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 6, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 7, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_RELEASE, 7, 0, 5, 1, 32'h12345678), 0, '0},
      '{mk(rrbp_pkg::ACT_RELEASE, 7, 0, 5, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_DONE, 7, 0, 32'hFFFFFFFF, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_RESERVE, 7, 0, 8, 0, 0), 0, '0},
      '{mk(rrbp_pkg::ACT_CLEAR, 7, 0, 0, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_OK)},
      '{mk(rrbp_pkg::ACT_DONE, 7, 0, 6, 0, 0), 1, rp(0, 0, rrbp_pkg::ST_NO_MAPPING)}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.req, row.typed, row.rep);
    end

    // Fill the in-flight table to reach the table-full case.
    for (int s = 0; s < 5; s++)
      for (int b = 0; b < rrbp_pkg::POOL_DEPTH; b++)
        send_request(mk(rrbp_pkg::ACT_ADD, s, 100 + s * 8 + b, 0, 0, 0), 0, '0);
    for (int t = 0; t < rrbp_pkg::IN_FLIGHT + 1; t++)
      send_request(mk(rrbp_pkg::ACT_RESERVE, t % 5, 0, 1000 + t, 0, 0), 0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 66 : 0;
      receiver_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < rrbp_pkg::SURFACES; s++)
        send_request(mk(rrbp_pkg::ACT_CLEAR, s, 0, 0, 0, 0), 0, '0);
      n_random = 0;
      while (n_random < 200) begin
        send_request(random_request(), 0, '0);
        n_random++;
        if (n_random == 100) begin
          in_valid <= 0;
          while (expected_replies.size() != 0) @(negedge clk);
        end
      end
    end

    in_valid <= 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> sim.f
design/rrbp_pkg.sv
design/rrbp_ram.sv
design/round_robin_buffer_pool_reserver.sv
tb/sv/round_robin_buffer_pool_reserver_tb.sv
